[design/rational_arithmetic_unit_assert.svh]
// assertion macros for the rational arithmetic unit
// expects signals named clock and reset in the module that uses them
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rau assertion failed");

// next-cycle implication
`define RAU_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rau assertion failed");

`endif

[design/rau_pkg.sv]
// shared types and constants of the rational arithmetic unit
// no dependencies
package rau_pkg;

   localparam int FIELD_BITS    = 32;
   localparam int WORD_BITS_DEF = 32;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } command_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[design/rau_front.sv]
// front end: accepts an item and forms numerator and denominator products
// with three shift-add multiplier lanes; depends on rau_pkg
module rau_front #(
   parameter int W = rau_pkg::WORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_a_num,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_a_den,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_b_num,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_b_den,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output logic [2*W-1:0]                        push_data
);
   import rau_pkg::*;

   localparam int CW = $clog2(W);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_PUSH} state_type;

   state_type       state_ff, state_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   command_type     cmd_ff, cmd_in;
   logic [W-1:0]    mcand_ff [3];
   logic [W-1:0]    mcand_in [3];
   logic [W-1:0]    mplier_ff [3];
   logic [W-1:0]    mplier_in [3];
   logic [W-1:0]    acc_ff [3];
   logic [W-1:0]    acc_in [3];
   logic [W-1:0]    an, ad, bn, bd;
   logic [W-1:0]    num;

   assign an = W'(req_a_num);
   assign ad = W'(req_a_den);
   assign bn = W'(req_b_num);
   assign bd = W'(req_b_den);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd_in   = cmd_ff;
      for (int i = 0; i < 3; i++) begin
         mcand_in[i]  = mcand_ff[i];
         mplier_in[i] = mplier_ff[i];
         acc_in[i]    = acc_ff[i];
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = command_type'(req_command);
               cnt_in   = '0;
               state_in = ST_MUL;
               for (int i = 0; i < 3; i++) acc_in[i] = '0;
               mcand_in[2] = ad;
               unique case (command_type'(req_command)) inside
                  CMD_ADD, CMD_SUB: begin
                     mcand_in[0] = an; mplier_in[0] = bd;
                     mcand_in[1] = bn; mplier_in[1] = ad;
                     mplier_in[2] = bd;
                  end
                  CMD_MUL: begin
                     mcand_in[0] = an; mplier_in[0] = bn;
                     mcand_in[1] = '0; mplier_in[1] = '0;
                     mplier_in[2] = bd;
                  end
                  default: begin
                     mcand_in[0] = an; mplier_in[0] = bd;
                     mcand_in[1] = '0; mplier_in[1] = '0;
                     mplier_in[2] = bn;
                  end
               endcase
            end
         end
         ST_MUL: begin
            for (int i = 0; i < 3; i++) begin
               acc_in[i]    = mplier_ff[i][0] ? acc_ff[i] + mcand_ff[i] : acc_ff[i];
               mcand_in[i]  = {mcand_ff[i][W-2:0], 1'b0};
               mplier_in[i] = {1'b0, mplier_ff[i][W-1:1]};
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (push_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      cmd_ff <= cmd_in;
      for (int i = 0; i < 3; i++) begin
         mcand_ff[i]  <= mcand_in[i];
         mplier_ff[i] <= mplier_in[i];
         acc_ff[i]    <= acc_in[i];
      end
   end

   always_comb begin
      case (cmd_ff)
         CMD_ADD: num = acc_ff[0] + acc_ff[1];
         CMD_SUB: num = acc_ff[0] - acc_ff[1];
         default: num = acc_ff[0];
      endcase
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign push_valid = (state_ff == ST_PUSH);
   assign push_data  = {num, acc_ff[2]};

endmodule

[design/rau_queue.sv]
// two-entry queue between front and back end
// depends on rau_pkg
module rau_queue #(
   parameter int DW = 2 * rau_pkg::WORD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   input  logic [DW-1:0]         push_data,
   input  logic                  pop_ready,
   output logic [DW-1:0]         pop_data,
   output rau_pkg::q_status_type status
);
   import rau_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int NW = $clog2(QUEUE_DEPTH + 1);

   logic [DW-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign status.full  = (count_ff == NW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push_valid && !status.full;
   assign do_pop       = pop_ready && !status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

[design/rau_back.sv]
// back end: euclid gcd reduction on a shared radix-2 divider, sign fix
// and output register; depends on rau_pkg
module rau_back #(
   parameter int W = rau_pkg::WORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  pop_valid,
   output logic                                  pop_ready,
   input  logic [2*W-1:0]                        pop_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rau_pkg::FIELD_BITS-1:0] rsp_res_num,
   output logic signed [rau_pkg::FIELD_BITS-1:0] rsp_res_den,
   output logic                                  rsp_zero_den
);
   import rau_pkg::*;

   localparam int CW = $clog2(W);

   typedef enum logic [2:0] {ST_IDLE, ST_GCD, ST_DIV, ST_OUT} state_type;
   typedef enum logic [1:0] {K_REM, K_QN, K_QD} kind_type;

   state_type     state_ff, state_in;
   kind_type      kind_ff, kind_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  a_ff, a_in, b_ff, b_in, n_ff, n_in, d_ff, d_in;
   logic [W-1:0]  q_ff, q_in, r_ff, r_in, dvs_ff, dvs_in;
   logic          negq_ff, negq_in, negr_ff, negr_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] num_ff, num_in, den_ff, den_in;
   logic          zero_ff, zero_in;
   logic [W:0]    shifted;
   logic          ge;
   logic [W-1:0]  quot, rem, dq;

   function automatic logic [W-1:0] mag(input logic [W-1:0] x);
      return x[W-1] ? -x : x;
   endfunction

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cnt_in       = cnt_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      dvs_in       = dvs_ff;
      negq_in      = negq_ff;
      negr_in      = negr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      num_in       = num_ff;
      den_in       = den_ff;
      zero_in      = zero_ff;
      pop_ready    = 1'b0;
      shifted      = {r_ff, q_ff[W-1]};
      ge           = shifted >= {1'b0, dvs_ff};
      quot         = '0;
      rem          = '0;
      dq           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               n_in     = pop_data[2*W-1:W];
               d_in     = pop_data[W-1:0];
               a_in     = pop_data[2*W-1:W];
               b_in     = pop_data[W-1:0];
               state_in = ST_GCD;
            end
         end
         ST_GCD: begin
            cnt_in   = '0;
            r_in     = '0;
            state_in = ST_DIV;
            if (b_ff == '0) begin
               if (a_ff == '0) begin
                  state_in = ST_OUT;
               end else begin
                  kind_in = K_QN;
                  q_in    = mag(n_ff);
                  dvs_in  = mag(a_ff);
                  negq_in = n_ff[W-1] ^ a_ff[W-1];
                  negr_in = n_ff[W-1];
               end
            end else begin
               kind_in = K_REM;
               q_in    = mag(a_ff);
               dvs_in  = mag(b_ff);
               negq_in = a_ff[W-1] ^ b_ff[W-1];
               negr_in = a_ff[W-1];
            end
         end
         ST_DIV: begin
            r_in   = ge ? W'(shifted - {1'b0, dvs_ff}) : W'(shifted);
            q_in   = {q_ff[W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            quot   = negq_ff ? -q_in : q_in;
            rem    = negr_ff ? -r_in : r_in;
            if (cnt_ff == CW'(W - 1)) begin
               cnt_in = '0;
               r_in   = '0;
               unique case (kind_ff)
                  K_REM: begin
                     a_in     = b_ff;
                     b_in     = rem;
                     state_in = ST_GCD;
                  end
                  K_QN: begin
                     n_in    = quot;
                     kind_in = K_QD;
                     q_in    = mag(d_ff);
                     dvs_in  = mag(a_ff);
                     negq_in = d_ff[W-1] ^ a_ff[W-1];
                     negr_in = d_ff[W-1];
                  end
                  default: begin
                     dq       = quot;
                     n_in     = dq[W-1] ? -n_ff : n_ff;
                     d_in     = dq[W-1] ? -dq : dq;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               num_in       = FIELD_BITS'(n_ff);
               den_in       = FIELD_BITS'(d_ff);
               zero_in      = (d_ff == '0);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      cnt_ff  <= cnt_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      q_ff    <= q_in;
      r_ff    <= r_in;
      dvs_ff  <= dvs_in;
      negq_ff <= negq_in;
      negr_ff <= negr_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      zero_ff <= zero_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_res_num  = num_ff;
   assign rsp_res_den  = den_ff;
   assign rsp_zero_den = zero_ff;

endmodule

[design/rational_arithmetic_unit.sv]
// rational arithmetic unit: front end multiplies with shift-add lanes, back end
// reduces by gcd with one radix-2 divider; the number of euclid steps is at
// most about 1.44 * WORD_BITS. one item in the back end at a time, and the
// back end takes no new item until the last result is in the output register.
// synchronous active-high reset empties the queue and clears all handshakes
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit #(
   parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_command,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_a_num,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_a_den,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_b_num,
   input  logic signed [rau_pkg::FIELD_BITS-1:0] req_b_den,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [rau_pkg::FIELD_BITS-1:0] rsp_res_num,
   output logic signed [rau_pkg::FIELD_BITS-1:0] rsp_res_den,
   output logic                                  rsp_zero_den
);
   import rau_pkg::*;

   logic                   q_push, q_pop, q_pop_ready;
   logic [2*WORD_BITS-1:0] q_push_data, q_pop_data;
   q_status_type           q_status;

   assign q_pop = q_pop_ready && !q_status.empty;

   rau_front #(.W(WORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .req_a_num   (req_a_num),
      .req_a_den   (req_a_den),
      .req_b_num   (req_b_num),
      .req_b_den   (req_b_den),
      .push_valid  (q_push),
      .push_ready  (!q_status.full),
      .push_data   (q_push_data)
   );

   rau_queue #(.DW(2 * WORD_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_data  (q_push_data),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data),
      .status     (q_status)
   );

   rau_back #(.W(WORD_BITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (!q_status.empty),
      .pop_ready    (q_pop_ready),
      .pop_data     (q_pop_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_res_num  (rsp_res_num),
      .rsp_res_den  (rsp_res_den),
      .rsp_zero_den (rsp_zero_den)
   );

   `RAU_ASSERT_IMPL(a_queue_sane, 1'b1, !(q_status.full && q_status.empty))
   `RAU_ASSERT_NEXT(a_pop_frees_slot, q_pop && !q_push, !q_status.full)
   `RAU_ASSERT_NEXT(a_push_fills_slot, q_push && !q_status.full && !q_pop, !q_status.empty)

endmodule

[tb/sv/rau_checker.sv]
// checker for the rational arithmetic unit: predicts each reduced fraction
// from the accepted item and compares it with the result channel
// depends on rau_pkg
module rau_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_command,
   input  logic [31:0] req_a_num,
   input  logic [31:0] req_a_den,
   input  logic [31:0] req_b_num,
   input  logic [31:0] req_b_den,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_res_num,
   input  logic [31:0] rsp_res_den,
   input  logic        rsp_zero_den,
   output int          fail_count,
   output int          pending_count
);
   import rau_pkg::*;

   typedef struct packed {
      logic [31:0] num;
      logic [31:0] den;
      logic        zero_den;
   } fraction_type;

   fraction_type expected_fractions[$];

   function automatic logic [31:0] trunc_quot(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic logic [31:0] trunc_rem(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, r;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      r = ma % mb;
      return a[31] ? -r : r;
   endfunction

   function automatic fraction_type reduce_fraction(command_type cmd, logic [31:0] an,
                                                    logic [31:0] ad, logic [31:0] bn,
                                                    logic [31:0] bd);
      logic [31:0] n, d, g, x, t;
      fraction_type f;
      case (cmd)
         CMD_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
         CMD_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
         CMD_MUL: begin n = an * bn; d = ad * bd; end
         default: begin n = an * bd; d = ad * bn; end
      endcase
      g = n;
      x = d;
      while (x != 0) begin
         t = trunc_rem(g, x);
         g = x;
         x = t;
      end
      if (g != 0) begin
         n = trunc_quot(n, g);
         d = trunc_quot(d, g);
         if (d[31]) begin
            n = -n;
            d = -d;
         end
      end
      f.num = n;
      f.den = d;
      f.zero_den = (d == 0);
      return f;
   endfunction

   assign pending_count = expected_fractions.size();

   always @(posedge clock) begin
      fraction_type e;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_fractions.push_back(reduce_fraction(command_type'(req_command),
               req_a_num, req_a_den, req_b_num, req_b_den));
         if (rsp_valid && rsp_ready) begin
            if (expected_fractions.size() == 0) begin
               $display("%0t unexpected item num %h den %h zero %b", $time,
                        rsp_res_num, rsp_res_den, rsp_zero_den);
               fail_count <= fail_count + 1;
            end else begin
               e = expected_fractions.pop_front();
               if (e.num !== rsp_res_num || e.den !== rsp_res_den ||
                   e.zero_den !== rsp_zero_den) begin
                  $display("%0t mismatch expected %h/%h z%b actual %h/%h z%b", $time,
                           e.num, e.den, e.zero_den, rsp_res_num, rsp_res_den,
                           rsp_zero_den);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

[tb/sv/tb_rational_arithmetic_unit.sv]
// top of the rational arithmetic unit testbench: clock, reset, stimulus, verdict
// depends on rau_pkg, rau_checker and the unit itself
module tb_rational_arithmetic_unit;
   import rau_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [31:0] req_a_num, req_a_den, req_b_num, req_b_den;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_res_num, rsp_res_den;
   logic        rsp_zero_den;
   int          fail_count;
   int          pending_count;
   bit          hold_rsp;

   rational_arithmetic_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den), .rsp_zero_den(rsp_zero_den)
   );

   rau_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_command(req_command),
      .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_res_num(rsp_res_num), .rsp_res_den(rsp_res_den), .rsp_zero_den(rsp_zero_den),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic int gap_length();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 2) - 1;
         3: return 32'($signed($urandom_range(0, 40)) - 20);
         4: return 32'($signed($urandom_range(0, 2000)) - 1000);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_fraction(command_type cmd, logic [31:0] an, logic [31:0] ad,
                                logic [31:0] bn, logic [31:0] bd);
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_a_num   <= an;
      req_a_den   <= ad;
      req_b_num   <= bn;
      req_b_den   <= bd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_random(bit gaps);
      int g;
      send_fraction(command_type'($urandom_range(0, 3)), random_word(), random_word(),
                    random_word(), random_word());
      g = gaps ? gap_length() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else if (hold_rsp)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   initial begin
      #100000000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      command_type c;
      hold_rsp    = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_command = CMD_ADD;
      req_a_num   = 0;
      req_a_den   = 0;
      req_b_num   = 0;
      req_b_den   = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // extremes, every operation, zero denominators, wrap cases
      c = c.first();
      do begin
         send_fraction(c, 32'd1, 32'd2, 32'd1, 32'd3);
         send_fraction(c, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 32'd1);
         send_fraction(c, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
         send_fraction(c, 32'd0, 32'd0, 32'd0, 32'd0);
         send_fraction(c, 32'd5, 32'd0, 32'd0, 32'd7);
         c = c.next();
      end while (c != c.first());
      send_fraction(CMD_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_fraction(CMD_DIV, 32'd6, 32'hffff_fffc, 32'd9, 32'd2);
      req_valid <= 1'b0;
      @(posedge clock);

      // drain completely before going on
      while (pending_count != 0) @(posedge clock);

      // receiver holds off while sender keeps offering
      fork
         begin
            hold_rsp = 1'b1;
            repeat (800) @(posedge clock);
            hold_rsp = 1'b0;
         end
         repeat (6) send_random(1'b0);
      join
      req_valid <= 1'b0;

      for (int i = 0; i < 1200; i++)
         send_random(i % 300 >= 250 ? 1'b0 : 1'b1);
      req_valid <= 1'b0;
      @(posedge clock);

      while (pending_count != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end
endmodule

[sim.f]
+incdir+design
design/rau_pkg.sv
design/rau_front.sv
design/rau_queue.sv
design/rau_back.sv
design/rational_arithmetic_unit.sv
tb/sv/rau_checker.sv
tb/sv/tb_rational_arithmetic_unit.sv
